[hw/rtl/gnss_binary_frame_text_splitter_defines.svh]
// Assertion macros shared by the splitter checker.
// Depends on nothing; included by files that assert.
`ifndef GNSS_BINARY_FRAME_TEXT_SPLITTER_DEFINES_SVH
`define GNSS_BINARY_FRAME_TEXT_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GBFTS_ASSERT_NOW(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gbfts assertion failed");

// Next-cycle implication, disabled in reset.
`define GBFTS_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gbfts assertion failed");

`endif

[hw/rtl/gbfts_pkg.sv]
// Types and constants of the binary frame / text line splitter.
// Depends on nothing; used by every splitter file but gbfts_stream_if.
package gbfts_pkg;

	localparam int unsigned LINE_STORE_SIZE_DEF = 256;

	localparam logic [7:0] SYNC_ONE = 8'hB5;
	localparam logic [7:0] SYNC_TWO = 8'h62;
	localparam logic [7:0] NEWLINE  = 8'h0A;

	localparam logic [16:0] POS_IDLE  = 17'd0;
	localparam logic [16:0] POS_SYNC2 = 17'd1;
	localparam logic [16:0] POS_CLASS = 17'd2;
	localparam logic [16:0] POS_ID    = 17'd3;
	localparam logic [16:0] POS_LENLO = 17'd4;
	localparam logic [16:0] POS_LENHI = 17'd5;
	localparam logic [16:0] POS_BODY  = 17'd6;

	typedef enum logic [2:0] {
		KIND_TEXT    = 3'd0,
		KIND_OTHER   = 3'd1,
		KIND_FRAME   = 3'd2,
		KIND_PAYLOAD = 3'd3,
		KIND_END     = 3'd4
	} byte_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       taken_by_other;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [2:0]  byte_kind;
		logic [15:0] payload_index;
		logic [7:0]  frame_class;
		logic [7:0]  frame_id;
		logic [15:0] frame_length;
		logic        checksum_error;
		logic        line_end;
		logic [7:0]  line_length;
	} out_item_t;

	typedef struct packed {
		logic        used;
		byte_kind_t  kind;
		logic [15:0] pidx;
		logic [7:0]  cls;
		logic [7:0]  id;
		logic [15:0] len;
		logic        cerr;
	} frame_res_t;

	typedef struct packed {
		logic       lend;
		logic [7:0] llen;
	} line_res_t;

endpackage

[hw/rtl/gbfts_stream_if.sv]
// Valid/ready request channel with a typed payload.
// Depends on nothing; payload type set per instance.
interface gbfts_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/gbfts_frame.sv]
// Binary frame tracker: sync, header, payload, Fletcher-8 check.
// Depends on gbfts_pkg.
module gbfts_frame
	import gbfts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] data_byte,
	input  logic       taken_by_other,
	input  logic       line_idle,
	output frame_res_t res
);

	logic [16:0] pos_q, pos_d;
	logic [7:0]  cls_q, cls_d, id_q, id_d, sum_a_q, sum_a_d, sum_b_q, sum_b_d;
	logic [15:0] len_q, len_d;
	logic [16:0] off;
	logic [7:0]  sa_add, sb_add;
	logic        adv;

	assign off    = pos_q - POS_BODY;
	assign sa_add = sum_a_q + data_byte;
	assign sb_add = sum_b_q + sa_add;

	always_comb begin
		pos_d   = pos_q;
		cls_d   = cls_q;
		id_d    = id_q;
		len_d   = len_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		adv     = 1'b0;
		res     = '0;
		res.kind = KIND_TEXT;
		if (line_idle && pos_q == POS_IDLE && taken_by_other) begin
			res.used = 1'b1;
			res.kind = KIND_OTHER;
		end else if (line_idle) begin
			priority if (pos_q == POS_IDLE) begin
				if (data_byte == SYNC_ONE) begin
					adv   = 1'b1;
					pos_d = POS_SYNC2;
				end
			end else if (pos_q == POS_SYNC2) begin
				if (data_byte == SYNC_TWO) begin
					adv     = 1'b1;
					pos_d   = POS_CLASS;
					sum_a_d = '0;
					sum_b_d = '0;
				end
			end else if (pos_q < POS_BODY) begin
				adv     = 1'b1;
				pos_d   = pos_q + 17'd1;
				sum_a_d = sa_add;
				sum_b_d = sb_add;
				unique case (pos_q)
					POS_CLASS: cls_d = data_byte;
					POS_ID:    id_d = data_byte;
					POS_LENLO: len_d = {8'h00, data_byte};
					default:   len_d = {data_byte, len_q[7:0]};
				endcase
			end else if (off < {1'b0, len_q}) begin
				adv      = 1'b1;
				pos_d    = pos_q + 17'd1;
				sum_a_d  = sa_add;
				sum_b_d  = sb_add;
				res.kind = KIND_PAYLOAD;
				res.pidx = off[15:0];
				res.cls  = cls_q;
				res.id   = id_q;
				res.len  = len_q;
			end else if (off == {1'b0, len_q}) begin
				if (data_byte == sum_a_q) begin
					adv   = 1'b1;
					pos_d = pos_q + 17'd1;
				end else begin
					res.cerr = 1'b1;
				end
			end else begin
				if (data_byte == sum_b_q) begin
					adv      = 1'b1;
					pos_d    = POS_IDLE;
					res.kind = KIND_END;
					res.cls  = cls_q;
					res.id   = id_q;
					res.len  = len_q;
				end else begin
					res.cerr = 1'b1;
				end
			end
			if (adv) begin
				res.used = 1'b1;
				if (res.kind == KIND_TEXT) begin
					res.kind = KIND_FRAME;
				end
			end else begin
				pos_d = POS_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_IDLE;
			cls_q   <= '0;
			id_q    <= '0;
			len_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (en) begin
			pos_q   <= pos_d;
			cls_q   <= cls_d;
			id_q    <= id_d;
			len_q   <= len_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
		end
	end

endmodule

[hw/rtl/gbfts_line.sv]
// Text line counter: counts bytes up to a newline, wraps at the store size.
// Depends on gbfts_pkg.
module gbfts_line
	import gbfts_pkg::*;
#(
	parameter int unsigned LINE_STORE_SIZE = LINE_STORE_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       text,
	input  logic [7:0] data_byte,
	output logic       line_idle,
	output line_res_t  res
);

	localparam int unsigned W  = $clog2(LINE_STORE_SIZE);
	localparam int unsigned CW = (W + 1 > 8) ? W + 1 : 8;

	logic [W-1:0]  pos_q, pos_d;
	logic [W:0]    nxt, wrapped;
	logic [CW-1:0] ext;

	assign line_idle = (pos_q == '0);
	assign nxt       = {1'b0, pos_q} + (W+1)'(1);
	assign wrapped   = (nxt >= (W+1)'(LINE_STORE_SIZE)) ? '0 : nxt;
	assign ext       = CW'(wrapped);

	always_comb begin
		pos_d = pos_q;
		res   = '0;
		if (text) begin
			pos_d = wrapped[W-1:0];
			if (wrapped != '0 && data_byte == NEWLINE) begin
				res.lend = 1'b1;
				res.llen = (ext > CW'(255)) ? 8'hFF : ext[7:0];
				pos_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (en) begin
			pos_q <= pos_d;
		end
	end

endmodule

[hw/rtl/gnss_binary_frame_text_splitter.sv]
// Binary frame / text line splitter for a mixed GNSS receiver byte stream.
// Depends on gbfts_pkg, gbfts_stream_if, gbfts_frame and gbfts_line.
//
// in_ch carries one received byte per request plus a flag that an outside
// deframer claims it; out_ch returns one request per byte that names what
// the byte was (text, other protocol, frame header, payload, frame end),
// with payload index, frame header fields, checksum error and line end.
// A byte accepted at a clock edge lands in the input register, is
// classified there against the frame and line state and moves to the result
// register once that register is free or being taken by out_ch; only then is
// its result offered. One byte per cycle is sustained while out_ch is ready; the
// frame and line state update as a byte moves from the input register to the
// result register, so each byte sees the state left by the one before it.
// A stalled receiver holds the result register; the input register still
// takes one more byte, then in_ch.ready drops until out_ch moves again.
// Reset (arst_n low) clears both registers' valid flags and returns the
// frame tracker and line counter to idle.
module gnss_binary_frame_text_splitter
	import gbfts_pkg::*;
#(
	parameter int unsigned LINE_STORE_SIZE = LINE_STORE_SIZE_DEF
) (
	input logic           clk,
	input logic           arst_n,
	gbfts_stream_if.sink   in_ch,
	gbfts_stream_if.source out_ch
);

	in_item_t   in_s1;
	logic       vld_s1;
	out_item_t  out_s2;
	logic       vld_s2;
	logic       adv_s1;
	logic       line_idle;
	frame_res_t fres;
	line_res_t  lres;

	assign adv_s1      = vld_s1 && (!vld_s2 || out_ch.ready);
	assign in_ch.ready = !vld_s1 || adv_s1;

	gbfts_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (adv_s1),
		.data_byte      (in_s1.data_byte),
		.taken_by_other (in_s1.taken_by_other),
		.line_idle      (line_idle),
		.res            (fres)
	);

	gbfts_line #(
		.LINE_STORE_SIZE (LINE_STORE_SIZE)
	) u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv_s1),
		.text      (!fres.used),
		.data_byte (in_s1.data_byte),
		.line_idle (line_idle),
		.res       (lres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				vld_s1 <= in_ch.valid;
			end
			if (adv_s1) begin
				vld_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			in_s1 <= in_ch.payload;
		end
		if (adv_s1) begin
			out_s2.byte_value     <= in_s1.data_byte;
			out_s2.byte_kind      <= fres.kind;
			out_s2.payload_index  <= fres.pidx;
			out_s2.frame_class    <= fres.cls;
			out_s2.frame_id       <= fres.id;
			out_s2.frame_length   <= fres.len;
			out_s2.checksum_error <= fres.cerr;
			out_s2.line_end       <= lres.lend;
			out_s2.line_length    <= lres.llen;
		end
	end

	assign out_ch.valid   = vld_s2;
	assign out_ch.payload = out_s2;

endmodule

[hw/rtl/gbfts_checker.sv]
// Port-level checks of the splitter, bound to the top level.
// Depends on gbfts_pkg and the shared assertion macros.
`include "gnss_binary_frame_text_splitter_defines.svh"

module gbfts_checker
	import gbfts_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	`GBFTS_ASSERT_NOW(a_payload_clean, clk, arst_n, out_valid && out_item.byte_kind == KIND_PAYLOAD, !out_item.checksum_error && !out_item.line_end)
	`GBFTS_ASSERT_NOW(a_line_end_text, clk, arst_n, out_valid && out_item.line_end, out_item.byte_kind == KIND_TEXT && out_item.byte_value == NEWLINE && out_item.line_length != 8'd0)
	`GBFTS_ASSERT_NOW(a_index_in_frame, clk, arst_n, out_valid && out_item.byte_kind == KIND_PAYLOAD, out_item.payload_index < out_item.frame_length)
	`GBFTS_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))

endmodule

bind gnss_binary_frame_text_splitter gbfts_checker u_gbfts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_item  (out_ch.payload)
);

[tb/gbfts_byte_checker.sv]
// Checker for the binary frame / text line splitter: tracks frame and line
// state per accepted byte request and compares each result request with it.
// Depends on gbfts_pkg.
module gbfts_byte_checker
	import gbfts_pkg::*;
#(
	parameter int unsigned LINE_STORE_SIZE = LINE_STORE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_req,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_res,
	output int unsigned fail_count,
	output int unsigned pending
);

	out_item_t   result_q[$];
	out_item_t   want;

	logic [16:0] frm_pos;
	logic [7:0]  frm_cls;
	logic [7:0]  frm_id;
	logic [15:0] frm_len;
	logic [7:0]  fl_a;
	logic [7:0]  fl_b;
	int unsigned txt_cnt;

	function automatic out_item_t classify_byte(input in_item_t req);
		out_item_t   r;
		logic        taken;
		logic        adv;
		logic [7:0]  b;
		logic [16:0] body;
		r = '0;
		b = req.data_byte;
		r.byte_value = b;
		r.byte_kind = KIND_TEXT;
		taken = 1'b0;
		if (txt_cnt == 0 && frm_pos == POS_IDLE && req.taken_by_other) begin
			taken = 1'b1;
			r.byte_kind = KIND_OTHER;
		end
		if (!taken && txt_cnt == 0) begin
			adv = 1'b0;
			body = frm_pos - POS_BODY;
			if (frm_pos == POS_IDLE) begin
				if (b == SYNC_ONE) begin
					frm_pos = POS_SYNC2;
					adv = 1'b1;
					r.byte_kind = KIND_FRAME;
				end
			end else if (frm_pos == POS_SYNC2) begin
				if (b == SYNC_TWO) begin
					frm_pos = POS_CLASS;
					fl_a = '0;
					fl_b = '0;
					adv = 1'b1;
					r.byte_kind = KIND_FRAME;
				end
			end else if (frm_pos <= POS_LENHI) begin
				case (frm_pos)
					POS_CLASS: frm_cls = b;
					POS_ID: frm_id = b;
					POS_LENLO: frm_len = {8'd0, b};
					default: frm_len[15:8] = b;
				endcase
				fl_a = fl_a + b;
				fl_b = fl_b + fl_a;
				frm_pos = frm_pos + 17'd1;
				adv = 1'b1;
				r.byte_kind = KIND_FRAME;
			end else if (body < {1'b0, frm_len}) begin
				fl_a = fl_a + b;
				fl_b = fl_b + fl_a;
				r.byte_kind = KIND_PAYLOAD;
				r.payload_index = body[15:0];
				r.frame_class = frm_cls;
				r.frame_id = frm_id;
				r.frame_length = frm_len;
				frm_pos = frm_pos + 17'd1;
				adv = 1'b1;
			end else if (body == {1'b0, frm_len}) begin
				if (b == fl_a) begin
					frm_pos = frm_pos + 17'd1;
					adv = 1'b1;
					r.byte_kind = KIND_FRAME;
				end else begin
					r.checksum_error = 1'b1;
				end
			end else begin
				if (b == fl_b) begin
					r.byte_kind = KIND_END;
					r.frame_class = frm_cls;
					r.frame_id = frm_id;
					r.frame_length = frm_len;
					frm_pos = POS_IDLE;
					adv = 1'b1;
				end else begin
					r.checksum_error = 1'b1;
				end
			end
			if (adv) taken = 1'b1;
			else frm_pos = POS_IDLE;
		end
		if (!taken) begin
			r.byte_kind = KIND_TEXT;
			txt_cnt = txt_cnt + 1;
			if (txt_cnt >= LINE_STORE_SIZE) txt_cnt = 0;
			if (txt_cnt > 0 && b == NEWLINE) begin
				r.line_end = 1'b1;
				r.line_length = (txt_cnt > 255) ? 8'd255 : 8'(txt_cnt);
				txt_cnt = 0;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			fail_count++;
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q.delete();
			fail_count = 0;
			pending = 0;
			frm_pos = POS_IDLE;
			frm_cls = '0;
			frm_id = '0;
			frm_len = '0;
			fl_a = '0;
			fl_b = '0;
			txt_cnt = 0;
		end else begin
			if (in_valid && in_ready) result_q.push_back(classify_byte(in_req));
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result: expected none actual %h", $time, out_res);
				end else begin
					want = result_q.pop_front();
					check_field("byte_value", want.byte_value, out_res.byte_value);
					check_field("byte_kind", want.byte_kind, out_res.byte_kind);
					check_field("payload_index", want.payload_index, out_res.payload_index);
					check_field("frame_class", want.frame_class, out_res.frame_class);
					check_field("frame_id", want.frame_id, out_res.frame_id);
					check_field("frame_length", want.frame_length, out_res.frame_length);
					check_field("checksum_error", want.checksum_error, out_res.checksum_error);
					check_field("line_end", want.line_end, out_res.line_end);
					check_field("line_length", want.line_length, out_res.line_length);
				end
			end
			pending = result_q.size();
		end
	end

endmodule

[tb/tb_gnss_binary_frame_text_splitter.sv]
// Top of the splitter testbench: drives directed and random byte requests
// with random idling on both channels and reports the verdict.
// Depends on gbfts_pkg, gbfts_stream_if, the splitter and gbfts_byte_checker.
module tb_gnss_binary_frame_text_splitter;
	import gbfts_pkg::*;

	localparam int unsigned LINE_STORE = LINE_STORE_SIZE_DEF;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned TAIL_CYCLES = 20;

	typedef enum int unsigned {
		FLAW_NONE,
		FLAW_SUM_A,
		FLAW_SUM_B,
		FLAW_SYNC
	} frame_flaw_t;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned sent_count;
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned pending;

	gbfts_stream_if #(.payload_t(in_item_t)) in_ch ();
	gbfts_stream_if #(.payload_t(out_item_t)) out_ch ();

	gnss_binary_frame_text_splitter #(
		.LINE_STORE_SIZE(LINE_STORE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	gbfts_byte_checker #(
		.LINE_STORE_SIZE(LINE_STORE)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_req(in_ch.payload),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_res(out_ch.payload),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] c);
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == a || b == c);
		return b;
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(1));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic taken);
		logic rdy;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= in_item_t'{data_byte: b, taken_by_other: taken};
		rdy = 1'b0;
		while (!rdy) begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end
		sent_count++;
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
			input logic [15:0] len, input frame_flaw_t flaw);
		logic [7:0] hdr [4];
		logic [7:0] sa;
		logic [7:0] sb;
		logic [7:0] b;
		sa = '0;
		sb = '0;
		hdr = '{cls, id, len[7:0], len[15:8]};
		send_byte(SYNC_ONE, 1'b0);
		if (flaw == FLAW_SYNC) begin
			send_byte(byte_except(SYNC_TWO, SYNC_TWO), coin());
			return;
		end
		send_byte(SYNC_TWO, coin());
		foreach (hdr[k]) begin
			sa = sa + hdr[k];
			sb = sb + sa;
			send_byte(hdr[k], coin());
		end
		for (int unsigned i = 0; i < len; i++) begin
			b = 8'($urandom_range(255));
			sa = sa + b;
			sb = sb + sa;
			send_byte(b, coin());
		end
		send_byte((flaw == FLAW_SUM_A) ? sa ^ 8'($urandom_range(255, 1)) : sa, coin());
		if (flaw == FLAW_SUM_A) return;
		send_byte((flaw == FLAW_SUM_B) ? sb ^ 8'($urandom_range(255, 1)) : sb, coin());
	endtask

	// hold the first byte off the sync pattern so the line really opens
	task automatic send_line(input int unsigned n);
		if (n > 0) send_byte(byte_except(NEWLINE, SYNC_ONE), 1'b0);
		for (int unsigned i = 1; i < n; i++) send_byte(byte_except(NEWLINE, NEWLINE), coin());
		send_byte(NEWLINE, (n > 0) ? coin() : 1'b0);
	endtask

	task automatic send_mix(input int unsigned target);
		int unsigned pick;
		int unsigned n;
		logic [15:0] len;
		while (sent_count < target) begin
			pick = $urandom_range(99);
			len = ($urandom_range(9) == 0) ? 16'($urandom_range(300)) : 16'($urandom_range(12));
			if (pick < 45) begin
				send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, FLAW_NONE);
			end else if (pick < 55) begin
				send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, FLAW_SUM_A);
				send_byte(NEWLINE, 1'b0);
			end else if (pick < 62) begin
				send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, FLAW_SUM_B);
				send_byte(NEWLINE, 1'b0);
			end else if (pick < 67) begin
				send_frame('0, '0, '0, FLAW_SYNC);
				send_byte(NEWLINE, 1'b0);
			end else if (pick < 85) begin
				n = ($urandom_range(29) == 0) ? $urandom_range(300, 200) : $urandom_range(40);
				send_line(n);
			end else if (pick < 92) begin
				n = $urandom_range(4, 1);
				repeat (n) send_byte(8'($urandom_range(255)), 1'b1);
			end else begin
				n = $urandom_range(8, 1);
				repeat (n) send_byte(8'($urandom_range(255)), coin());
				send_byte(NEWLINE, 1'b0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		tx_idle_pct = 33;
		rx_idle_pct = 62;
		sent_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_byte(8'h00, 1'b1);
		send_byte(NEWLINE, 1'b0);
		send_frame(8'hFF, 8'h00, 16'd0, FLAW_NONE);
		send_byte(SYNC_ONE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(NEWLINE, 1'b1);
		send_frame(8'h01, 8'h02, 16'd1, FLAW_SUM_A);
		send_byte(SYNC_ONE, 1'b1);
		send_byte(NEWLINE, 1'b0);

		send_mix(150);
		tx_idle_pct = 62;
		rx_idle_pct = 33;
		send_mix(300);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_line(255);
		send_line(254);
		send_byte(NEWLINE, 1'b0);
		send_mix(sent_count + 40);
		in_ch.valid <= 1'b0;

		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
